// ----- src/canonical_kmer_hasher_assert.svh -----
// Assertion macros for the canonical k-mer hasher checker.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef CANONICAL_KMER_HASHER_ASSERT_SVH
`define CANONICAL_KMER_HASHER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CKH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CKH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ckh_pkg.sv -----
// Package for the canonical k-mer hasher: field widths, base codes and hash mix steps.
// It has no dependencies and is imported by the top level and its checker.
package ckh_pkg;

    localparam int KMER_W      = 62;
    localparam int HASH_W      = 64;
    localparam int BUCKET_W    = 4;
    localparam int K_W         = 5;
    localparam int CHAR_W      = 8;
    localparam int MAX_K       = 31;
    localparam int NUM_BUCKETS = 16;

    typedef logic [KMER_W-1:0] t_kmer;
    typedef logic [HASH_W-1:0] t_hash;
    typedef logic [K_W-1:0]    t_klen;
    typedef logic [1:0]        t_base;

    localparam t_base BASE_A = 2'd0;
    localparam t_base BASE_C = 2'd1;
    localparam t_base BASE_G = 2'd2;
    localparam t_base BASE_T = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;

    function automatic t_base base_code(input logic [CHAR_W-1:0] ch);
        t_base code;
        case (ch)
            CHAR_A:  code = BASE_A;
            CHAR_C:  code = BASE_C;
            CHAR_G:  code = BASE_G;
            default: code = BASE_T;
        endcase
        return code;
    endfunction

    function automatic t_hash mix_a(input t_hash v);
        t_hash t;
        t = (~v) + (v << 21);
        return t ^ (t >> 24);
    endfunction

    function automatic t_hash mix_b(input t_hash v);
        t_hash t;
        t = v + (v << 3) + (v << 8);
        return t ^ (t >> 14);
    endfunction

    function automatic t_hash mix_c(input t_hash v);
        t_hash t;
        t = v + (v << 2) + (v << 4);
        return t ^ (t >> 28);
    endfunction

    function automatic t_hash mix_d(input t_hash v);
        return v + (v << 31);
    endfunction

endpackage

// ----- src/canonical_kmer_hasher.sv -----
// Top level of the canonical k-mer hasher: rolling windows and a six-stage hash pipeline.
// Depends on ckh_pkg for widths, base codes and the hash mix steps.

// The block takes one ASCII DNA character per transfer and can take a new one in every
// cycle while o_in_ready is high. A character with the start flag begins a new sequence.
// Once k characters of a sequence have been seen, each character yields one result: the
// canonical k-mer, its 64-bit hash and the low four hash bits as a bucket. Each result
// passes through the six pipeline stages (window snapshot, minimum, and four steps of the
// hash mix) before it is presented at the output. A stalled output holds the pipeline,
// and the input is refused only while all six stages hold results and the output is
// stalled. Writing the k-mer length clears both windows and the fill count; a length of
// zero counts as one.
module canonical_kmer_hasher
    import ckh_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [K_W-1:0]      i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [CHAR_W-1:0]   i_nucleotide_char,
    input  logic                i_sequence_start,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [KMER_W-1:0]   o_canonical_kmer,
    output logic [HASH_W-1:0]   o_hash_value,
    output logic [BUCKET_W-1:0] o_bucket
);

    t_klen r_k;
    t_kmer r_fwd;
    t_kmer r_rev;
    t_klen r_fill;
    t_klen n_k;
    t_kmer n_fwd;
    t_kmer n_rev;
    t_klen n_fill;
    logic  n_emit;

    logic  r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic  rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    t_kmer r_fwd1, r_rev1;
    t_kmer r_can2, r_can3, r_can4, r_can5, r_can6;
    t_hash r_h3, r_h4, r_h5, r_h6;

    logic  in_xfer;
    t_base code;
    t_kmer mask;
    t_kmer fwd_base;
    t_kmer rev_base;
    t_klen fill_base;
    logic [K_W:0] k2;

    assign rdy6 = !r_v6 || i_out_ready;
    assign rdy5 = !r_v5 || rdy6;
    assign rdy4 = !r_v4 || rdy5;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;

    assign o_in_ready = rdy1;
    assign in_xfer    = i_in_valid && rdy1;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_k = t_klen'(1);
        end else if (int'(i_cfg_wdata) > MAX_K) begin
            n_k = t_klen'(MAX_K);
        end else begin
            n_k = i_cfg_wdata;
        end
    end

    always_comb begin
        code      = base_code(i_nucleotide_char);
        k2        = {r_k, 1'b0};
        mask      = (t_kmer'(1) << k2) - t_kmer'(1);
        fwd_base  = i_sequence_start ? '0 : r_fwd;
        rev_base  = i_sequence_start ? '0 : r_rev;
        fill_base = i_sequence_start ? '0 : r_fill;
        n_fwd     = ((fwd_base << 2) | t_kmer'(code)) & mask;
        n_rev     = ((rev_base >> 2) | (t_kmer'(~code) << (k2 - (K_W+1)'(2)))) & mask;
        n_fill    = (fill_base < r_k) ? fill_base + t_klen'(1) : fill_base;
        n_emit    = (n_fill == r_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= t_klen'(MAX_K);
            r_fwd  <= '0;
            r_rev  <= '0;
            r_fill <= '0;
        end else if (i_cfg_we) begin
            r_k    <= n_k;
            r_fwd  <= '0;
            r_rev  <= '0;
            r_fill <= '0;
        end else if (in_xfer) begin
            r_fwd  <= n_fwd;
            r_rev  <= n_rev;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= in_xfer && n_emit;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
            if (rdy6) r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_fwd1 <= n_fwd;
            r_rev1 <= n_rev;
        end
        if (rdy2 && r_v1) begin
            r_can2 <= (r_fwd1 < r_rev1) ? r_fwd1 : r_rev1;
        end
        if (rdy3 && r_v2) begin
            r_can3 <= r_can2;
            r_h3   <= mix_a(t_hash'(r_can2));
        end
        if (rdy4 && r_v3) begin
            r_can4 <= r_can3;
            r_h4   <= mix_b(r_h3);
        end
        if (rdy5 && r_v4) begin
            r_can5 <= r_can4;
            r_h5   <= mix_c(r_h4);
        end
        if (rdy6 && r_v5) begin
            r_can6 <= r_can5;
            r_h6   <= mix_d(r_h5);
        end
    end

    assign o_out_valid      = r_v6;
    assign o_canonical_kmer = r_can6;
    assign o_hash_value     = r_h6;
    assign o_bucket         = BUCKET_W'(r_h6 % NUM_BUCKETS);

endmodule

// ----- src/ckh_checker.sv -----
// Port-level checker for the canonical k-mer hasher, bound to the top level below.
// Depends on ckh_pkg and the assertion macros in canonical_kmer_hasher_assert.svh.
`include "canonical_kmer_hasher_assert.svh"

module ckh_checker
    import ckh_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [KMER_W-1:0]   o_canonical_kmer,
    input logic [HASH_W-1:0]   o_hash_value,
    input logic [BUCKET_W-1:0] o_bucket
);

    // A stalled result keeps its valid and payload until its transfer.
    `CKH_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_canonical_kmer) && $stable(o_hash_value),
        "stalled result changed before its transfer")

    // The bucket is always the low bits of the hash of the same result.
    `CKH_ASSERT_NOW(a_bucket_match, o_out_valid,
        o_bucket == o_hash_value[BUCKET_W-1:0],
        "bucket does not match the hash value")

    // With the output stage empty, no stage can block the input.
    `CKH_ASSERT_NOW(a_ready_when_empty, !o_out_valid, o_in_ready,
        "input not ready while the output stage is empty")

endmodule

bind canonical_kmer_hasher ckh_checker u_ckh_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_canonical_kmer (o_canonical_kmer),
    .o_hash_value     (o_hash_value),
    .o_bucket         (o_bucket)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for canonical_kmer_hasher: random and directed DNA streams.
// Depends on ckh_pkg and the canonical_kmer_hasher top level; needs no other files.

module testbench;
    import ckh_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 12;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    typedef struct packed {
        t_kmer                kmer;
        t_hash                hash;
        logic [BUCKET_W-1:0]  bucket;
    } t_kmer_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [K_W-1:0]      i_cfg_wdata;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [CHAR_W-1:0]   i_nucleotide_char;
    logic                i_sequence_start;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [KMER_W-1:0]   o_canonical_kmer;
    logic [HASH_W-1:0]   o_hash_value;
    logic [BUCKET_W-1:0] o_bucket;

    t_kmer_result pending_kmers[$];
    t_klen        kmer_length_reg;
    logic [63:0]  fwd_window;
    logic [63:0]  rc_window;
    int           fill_chars;

    int  failures         = 0;
    int  results_checked  = 0;
    int  chars_sent       = 0;
    int  lengths_written  = 0;
    int  quiet_cycles     = 0;
    bit  steady_flow      = 1'b0;
    bit  sender_burst     = 1'b0;
    bit  holdoff_request  = 1'b0;

    canonical_kmer_hasher uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_nucleotide_char (i_nucleotide_char),
        .i_sequence_start  (i_sequence_start),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_canonical_kmer  (o_canonical_kmer),
        .o_hash_value      (o_hash_value),
        .o_bucket          (o_bucket)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int window_len();
        if (kmer_length_reg == '0) return 1;
        return int'(kmer_length_reg);
    endfunction

    function automatic void clear_windows();
        fwd_window = '0;
        rc_window  = '0;
        fill_chars = 0;
    endfunction

    function automatic t_base char_to_base(input logic [CHAR_W-1:0] ch);
        case (ch)
            CHAR_A:  return BASE_A;
            CHAR_C:  return BASE_C;
            CHAR_G:  return BASE_G;
            default: return BASE_T;
        endcase
    endfunction

    function automatic t_hash wang_hash64(input t_hash key);
        t_hash v;
        v = ~key + (key << 21);
        v = v ^ (v >> 24);
        v = v + (v << 3) + (v << 8);
        v = v ^ (v >> 14);
        v = v + (v << 2) + (v << 4);
        v = v ^ (v >> 28);
        v = v + (v << 31);
        return v;
    endfunction

    function automatic void roll_window(input logic [CHAR_W-1:0] ch, input logic seq_start);
        int           k;
        logic [63:0]  mask;
        logic [63:0]  canon;
        t_base        code;
        t_base        comp;
        t_kmer_result res;
        k    = window_len();
        mask = (64'd1 << (2 * k)) - 64'd1;
        code = char_to_base(ch);
        comp = ~code;
        if (seq_start) clear_windows();
        fwd_window = ((fwd_window << 2) | 64'(code)) & mask;
        rc_window  = ((rc_window >> 2) | (64'(comp) << (2 * k - 2))) & mask;
        if (fill_chars < k) fill_chars++;
        if (fill_chars >= k) begin
            canon      = (fwd_window < rc_window) ? fwd_window : rc_window;
            res.kmer   = canon[KMER_W-1:0];
            res.hash   = wang_hash64(canon);
            res.bucket = BUCKET_W'(res.hash % NUM_BUCKETS);
            pending_kmers = {pending_kmers, res};
        end
    endfunction

    function automatic void log_failure(input string msg);
        failures++;
        if (failures <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    endfunction

    function automatic void check_result();
        t_kmer_result want;
        if (pending_kmers.size() == 0) begin
            log_failure($sformatf("unexpected result: kmer %h hash %h bucket %h",
                                  o_canonical_kmer, o_hash_value, o_bucket));
            return;
        end
        want = pending_kmers.pop_front();
        results_checked++;
        if (o_canonical_kmer !== want.kmer)
            log_failure($sformatf("canonical_kmer: expected %h, got %h",
                                  want.kmer, o_canonical_kmer));
        if (o_hash_value !== want.hash)
            log_failure($sformatf("hash_value: expected %h, got %h", want.hash, o_hash_value));
        if (o_bucket !== want.bucket)
            log_failure($sformatf("bucket: expected %h, got %h", want.bucket, o_bucket));
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) check_result();
            if (i_cfg_we) begin
                kmer_length_reg = i_cfg_wdata;
                clear_windows();
            end
            if (i_in_valid && o_in_ready) roll_window(i_nucleotide_char, i_sequence_start);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
                     quiet_cycles, pending_kmers.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic int stall_len();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int sender_gap();
        if (steady_flow || sender_burst) return 0;
        if ($urandom_range(0, 1) == 0) return 0;
        return stall_len();
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        if ($urandom_range(0, 19) < 17) begin
            case ($urandom_range(0, 3))
                0:       return CHAR_A;
                1:       return CHAR_C;
                2:       return CHAR_G;
                default: return CHAR_T;
            endcase
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    initial begin : output_receiver
        int hold;
        hold = 0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (holdoff_request) begin
                i_out_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge i_clk);
                holdoff_request = 1'b0;
                hold = 0;
            end else if (steady_flow) begin
                i_out_ready <= 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                hold = stall_len();
            end else begin
                i_out_ready <= 1'b1;
                hold = $urandom_range(0, 24);
            end
            @(posedge i_clk);
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic seq_start);
        int gap;
        gap = sender_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_nucleotide_char <= ch;
        i_sequence_start  <= seq_start;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_kmers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_kmer_length(input t_klen value);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lengths_written++;
    endtask

    // Mostly well-formed sequences of at least k characters; some are cut short and
    // a few are broken by a restart in the middle.
    task automatic send_stream(input int count);
        int   sent;
        int   len;
        int   i;
        logic restart;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, window_len());
            else
                len = window_len() + $urandom_range(0, 40);
            if (len > count - sent) len = count - sent;
            for (i = 0; i < len; i++) begin
                restart = (i == 0) || ($urandom_range(0, 99) == 0);
                send_char(random_char(), restart);
            end
            sent += len;
        end
    endtask

    task automatic test_reset_length();
        send_stream(160);
    endtask

    task automatic test_directed_cases();
        write_kmer_length(5'd0);
        send_char(CHAR_A, 1'b1);
        send_char(CHAR_C, 1'b0);
        send_char(CHAR_G, 1'b0);
        send_char(CHAR_T, 1'b0);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h61, 1'b0);

        write_kmer_length(5'd2);
        send_char(CHAR_A, 1'b1);
        send_char(CHAR_T, 1'b0);
        send_char(CHAR_G, 1'b1);
        send_char(CHAR_C, 1'b0);
        send_char(CHAR_A, 1'b0);
        write_kmer_length(5'd2);
        send_char(CHAR_C, 1'b0);
        send_char(CHAR_G, 1'b0);

        write_kmer_length(5'd3);
        send_char(8'hAA, 1'b1);
        send_char(8'h55, 1'b0);
        send_char(CHAR_C, 1'b0);
        send_char(8'h80, 1'b0);
        send_char(CHAR_A, 1'b0);
    endtask

    task automatic test_random_lengths();
        t_klen lengths[$];
        int    i;
        lengths = '{5'd1, 5'd31, 5'd30, 5'd2};
        repeat (8) lengths = {lengths, t_klen'($urandom_range(0, MAX_K))};
        for (i = 0; i < lengths.size(); i++) begin
            write_kmer_length(lengths[i]);
            steady_flow = (i % 4 == 3);
            send_stream(100);
        end
        steady_flow = 1'b0;
    endtask

    // The receiver stops for a long stretch while the sender keeps offering transfers.
    task automatic test_output_holdoff();
        write_kmer_length(t_klen'($urandom_range(1, 8)));
        holdoff_request = 1'b1;
        sender_burst    = 1'b1;
        send_stream(150);
        sender_burst    = 1'b0;
    endtask

    task automatic test_sender_pause();
        write_kmer_length(t_klen'($urandom_range(3, 12)));
        repeat (3) begin
            send_stream(40);
            wait_for_drain();
        end
    endtask

    initial begin : test_sequence
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        i_in_valid        <= 1'b0;
        i_nucleotide_char <= '0;
        i_sequence_start  <= 1'b0;
        kmer_length_reg    = t_klen'(MAX_K);
        clear_windows();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_length();
        test_directed_cases();
        test_random_lengths();
        test_output_holdoff();
        test_sender_pause();
        wait_for_drain();

        if (pending_kmers.size() != 0)
            log_failure($sformatf("%0d results never arrived", pending_kmers.size()));
        $display("Summary: %0d characters sent, %0d k-mer results checked, %0d failures.",
                 chars_sent, results_checked, failures);
        $display("Summary: %0d k-mer length writes, output hold-off of %0d cycles included.",
                 lengths_written, HOLDOFF_CYCLES);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
